// File: sv/ikc_pkg.sv
package ikc_pkg;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_KERNEL_WIDTH  = 3'd0;
	localparam cfg_idx_t REG_KERNEL_HEIGHT = 3'd1;
	localparam cfg_idx_t REG_DIVISOR       = 3'd2;
	localparam cfg_idx_t REG_IMAGE_WIDTH   = 3'd3;
	localparam cfg_idx_t REG_IMAGE_HEIGHT  = 3'd4;
	localparam cfg_idx_t REG_PIXEL_MODE    = 3'd5;

	// Request commands.
	localparam logic CMD_COEF  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Pixel modes.
	localparam logic [1:0] MODE_MONO = 2'd0;
	localparam logic [1:0] MODE_BGR  = 2'd1;
	localparam logic [1:0] MODE_BGRA = 2'd2;

	localparam int PIX_W    = 24;
	localparam int COEF_W   = 16;
	localparam int MAX_ROWS = 2048;

	typedef logic [PIX_W-1:0] pix_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_COPY,
		ST_SCAN,
		ST_DIVS,
		ST_DIV
	} state_t;

	// Control from the sequencer to each channel lane.
	typedef struct packed {
		logic clr;
		logic tap_vld;
		logic div_start;
	} lane_ctl_t;

endpackage

// File: sv/ikc_line_buf.sv
module ikc_line_buf #(
	parameter int DEPTH = 2048,
	parameter int ROW_W = 144
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ROW_W-1:0]         wr_data,
	output logic [ROW_W-1:0]         rd_data
);
	import ikc_pkg::*;

	logic [ROW_W-1:0] mem [DEPTH];

	// One column of all buffered lines per entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/ikc_coef_ram.sv
module ikc_coef_ram #(
	parameter int DEPTH = 49,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic signed [ikc_pkg::COEF_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic signed [ikc_pkg::COEF_W-1:0] rd_data
);
	import ikc_pkg::*;

	logic signed [COEF_W-1:0] mem [DEPTH];

	// Coefficient table with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/ikc_lane.sv
module ikc_lane #(
	parameter int AW = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ikc_pkg::lane_ctl_t          ctl,
	input  logic signed [ikc_pkg::COEF_W-1:0] coef,
	input  logic [7:0]                  pix,
	input  logic signed [15:0]          dvs,
	output logic                        done,
	output logic [7:0]                  res
);
	import ikc_pkg::*;

	localparam int CW = $clog2(AW + 1);

	logic signed [24:0]   prod_s2;
	logic                 act_s2;
	logic signed [AW-1:0] acc_q;
	logic [AW-1:0]        num_q;
	logic [15:0]          rem_q;
	logic [15:0]          dmag_q;
	logic                 neg_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [16:0]          trial;
	logic                 qbit;

	// Product stage: signed coefficient times unsigned byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s2 <= 1'b0;
		end else begin
			act_s2 <= ctl.tap_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * $signed({1'b0, pix});
	end

	// Restoring division step, one quotient bit per cycle.
	always_comb begin
		trial = {rem_q, num_q[AW-1]};
		qbit  = (trial >= {1'b0, dmag_q});
	end

	// Accumulation and division on magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.clr) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.div_start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(AW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (act_s2) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
		if (ctl.div_start) begin
			num_q  <= acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
			rem_q  <= '0;
			dmag_q <= dvs[15] ? 16'(-dvs) : 16'(dvs);
			neg_q  <= acc_q[AW-1] ^ dvs[15];
		end else if (busy_q) begin
			num_q <= {num_q[AW-2:0], qbit};
			rem_q <= qbit ? 16'(trial - {1'b0, dmag_q}) : trial[15:0];
		end
	end

	// Clamp the truncated quotient to a byte.
	always_comb begin
		if (neg_q || num_q == '0) begin
			res = 8'd0;
		end else if (num_q >= AW'(255)) begin
			res = 8'hFF;
		end else begin
			res = num_q[7:0];
		end
	end

	assign done = done_q;

endmodule

// File: sv/image_kernel_convolution.sv
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
// in       in         in_valid / in_ready     cmd, coef_index, coef_value, pix_b/g/r
// out      out        out_valid / out_ready   out_x, out_y, out_b/g/r, out_alpha, frame_done
//
// A coefficient load leaves the port ready; a pixel that emits nothing passes
// only through the line store update. An emitting pixel also runs the serial
// tap scan through the coefficient RAM and the bit-serial divider, and no new
// request is taken until its result is loaded.
// Reset clears the counters and the sequencer; memories hold garbage until
// written. A stalled result is held in the output register while the next
// request is taken; only a finished division waits for it.
module image_kernel_convolution #(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_LINE   = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  ikc_pkg::cfg_idx_t     cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [5:0]            coef_index,
	input  logic signed [15:0]    coef_value,
	input  logic [7:0]            pix_b,
	input  logic [7:0]            pix_g,
	input  logic [7:0]            pix_r,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [10:0]           out_x,
	output logic [10:0]           out_y,
	output logic [7:0]            out_b,
	output logic [7:0]            out_g,
	output logic [7:0]            out_r,
	output logic [7:0]            out_alpha,
	output logic                  frame_done
);
	import ikc_pkg::*;

	localparam int NTAP = MAX_KERNEL * MAX_KERNEL;
	localparam int RING = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
	localparam int XW   = $clog2(MAX_LINE);
	localparam int RPW  = (RING > 1) ? $clog2(RING) : 1;
	localparam int CAW  = (NTAP > 1) ? $clog2(NTAP) : 1;
	localparam int KCW  = $clog2(MAX_KERNEL + 1);
	localparam int SCW  = $clog2(NTAP + 2);
	localparam int AW   = 25 + $clog2(NTAP + 1);
	localparam int ROW_W = RING * PIX_W;

	// Configuration registers.
	logic [2:0]         kw_q, kh_q;
	logic signed [15:0] dvs_q;
	logic [11:0]        iw_q, ih_q;
	logic [1:0]         mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q   <= 3'd3;
			kh_q   <= 3'd3;
			dvs_q  <= 16'sd1;
			iw_q   <= 12'd640;
			ih_q   <= 12'd480;
			mode_q <= MODE_MONO;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KERNEL_WIDTH:  kw_q   <= cfg_data[2:0];
				REG_KERNEL_HEIGHT: kh_q   <= cfg_data[2:0];
				REG_DIVISOR:       dvs_q  <= cfg_data;
				REG_IMAGE_WIDTH:   iw_q   <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:  ih_q   <= cfg_data[11:0];
				REG_PIXEL_MODE:    mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Setup check.
	logic setup_ok;
	always_comb begin
		setup_ok = (dvs_q != 16'sd0) && (mode_q <= MODE_BGRA) &&
			(iw_q != 12'd0) && (int'(iw_q) <= MAX_LINE) &&
			(ih_q != 12'd0) && (int'(ih_q) <= MAX_ROWS) &&
			kw_q[0] && kh_q[0] &&
			(int'(kw_q) <= MAX_KERNEL) && (int'(kh_q) <= MAX_KERNEL) &&
			({9'd0, kw_q} <= iw_q) && ({9'd0, kh_q} <= ih_q);
	end

	state_t state_q, state_d;
	logic   acc_pix, acc_coef;
	logic   lane_done;
	logic   out_load;
	logic [SCW-1:0] sc_q;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_pix  = in_valid && in_ready && (cmd == CMD_PIXEL);
	assign acc_coef = in_valid && in_ready && (cmd == CMD_COEF);

	// Raster counters and ring pointer.
	logic [XW-1:0]  x_q, cx_q;
	logic [10:0]    y_q, cy_q;
	logic [RPW-1:0] rp_q, crp_q;
	pix_t           px_q;
	int             wlim, hlim;

	always_comb begin
		wlim = (iw_q == 12'd0) ? 1 : ((int'(iw_q) > MAX_LINE) ? MAX_LINE : int'(iw_q));
		hlim = (ih_q == 12'd0) ? 1 : ((int'(ih_q) > MAX_ROWS) ? MAX_ROWS : int'(ih_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			rp_q <= '0;
		end else if (acc_pix) begin
			if (int'(x_q) + 1 >= wlim) begin
				x_q <= '0;
				if (int'(y_q) + 1 >= hlim) begin
					y_q  <= '0;
					rp_q <= '0;
				end else begin
					y_q  <= y_q + 1'b1;
					rp_q <= (int'(rp_q) == RING - 1) ? '0 : rp_q + 1'b1;
				end
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_pix) begin
			cx_q  <= x_q;
			cy_q  <= y_q;
			crp_q <= rp_q;
			px_q  <= {pix_r, pix_g, pix_b};
		end
	end

	// Line store, read at request time and written back in the cycle after.
	logic [ROW_W-1:0] lb_rd, lb_wr;

	always_comb begin
		lb_wr = lb_rd;
		lb_wr[int'(crp_q)*PIX_W +: PIX_W] = px_q;
	end

	ikc_line_buf #(
		.DEPTH (MAX_LINE),
		.ROW_W (ROW_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (acc_pix),
		.rd_addr (x_q),
		.wr_en   (state_q == ST_UPD),
		.wr_addr (cx_q),
		.wr_data (lb_wr),
		.rd_data (lb_rd)
	);

	// New window column: the incoming pixel at the bottom, older lines above.
	pix_t new_col [MAX_KERNEL];
	always_comb begin
		int slot;
		new_col[MAX_KERNEL-1] = px_q;
		for (int d = 1; d < MAX_KERNEL; d++) begin
			slot = int'(crp_q) + RING - d;
			if (slot >= RING) begin
				slot = slot - RING;
			end
			new_col[MAX_KERNEL-1-d] = lb_rd[slot*PIX_W +: PIX_W];
		end
	end

	// Emit decision for the buffered pixel.
	logic emit;
	always_comb begin
		emit = setup_ok && (int'(cx_q) < int'(iw_q)) && (int'(cy_q) < int'(ih_q)) &&
			(int'(cx_q) + 1 >= int'(kw_q)) && (int'(cy_q) + 1 >= int'(kh_q));
	end

	// Window shift line and its scan copy.
	pix_t win_q [NTAP];
	pix_t sh_q  [NTAP];
	logic [10:0] ox_q, oy_q;
	logic        fd_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			for (int r = 0; r < MAX_KERNEL; r++) begin
				for (int c = 0; c + 1 < MAX_KERNEL; c++) begin
					win_q[r*MAX_KERNEL+c] <= win_q[r*MAX_KERNEL+c+1];
				end
				win_q[r*MAX_KERNEL+MAX_KERNEL-1] <= new_col[r];
			end
			ox_q <= 11'(32'(cx_q) - 32'(kw_q >> 1));
			oy_q <= 11'(32'(cy_q) - 32'(kh_q >> 1));
			fd_q <= (int'(cx_q) + 1 == int'(iw_q)) && (int'(cy_q) + 1 == int'(ih_q));
		end
		if (state_q == ST_COPY) begin
			sh_q <= win_q;
		end else if (state_q == ST_SCAN) begin
			for (int i = 0; i + 1 < NTAP; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
		end
	end

	// Tap scan over the window in row-major order.
	logic [KCW-1:0] row_q, col_q;
	logic [CAW-1:0] ka_q;
	logic           issue, tap_act;
	logic           act_s1;
	pix_t           pix_s1;

	always_comb begin
		issue   = (state_q == ST_SCAN) && (int'(sc_q) < NTAP);
		tap_act = issue && (int'(row_q) >= MAX_KERNEL - int'(kh_q)) &&
			(int'(col_q) >= MAX_KERNEL - int'(kw_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			row_q  <= '0;
			col_q  <= '0;
			ka_q   <= '0;
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= tap_act;
			if (state_q == ST_COPY) begin
				sc_q  <= '0;
				row_q <= '0;
				col_q <= '0;
				ka_q  <= '0;
			end else if (state_q == ST_SCAN) begin
				sc_q <= sc_q + 1'b1;
				if (issue) begin
					if (int'(col_q) == MAX_KERNEL - 1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				if (tap_act) begin
					ka_q <= ka_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= sh_q[0];
	end

	// Coefficient table.
	logic [31:0]              cidx;
	logic signed [COEF_W-1:0] coef_s1;

	assign cidx = 32'(coef_index);

	ikc_coef_ram #(
		.DEPTH (NTAP),
		.AW    (CAW)
	) u_coef_ram (
		.clk     (clk),
		.wr_en   (acc_coef && (cidx < 32'(NTAP))),
		.wr_addr (cidx[CAW-1:0]),
		.wr_data (coef_value),
		.rd_en   (tap_act),
		.rd_addr (ka_q),
		.rd_data (coef_s1)
	);

	// Channel lanes.
	lane_ctl_t  lctl;
	logic [2:0] done_v;
	logic [7:0] res_v [3];

	assign lctl = '{
		clr:       (state_q == ST_COPY),
		tap_vld:   act_s1,
		div_start: (state_q == ST_DIVS)
	};

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		ikc_lane #(
			.AW (AW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.coef   (coef_s1),
			.pix    (pix_s1[8*ch +: 8]),
			.dvs    (dvs_q),
			.done   (done_v[ch]),
			.res    (res_v[ch])
		);
	end

	assign lane_done = &done_v;
	assign out_load  = (state_q == ST_DIV) && lane_done && (!out_valid || out_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc_pix) state_d = ST_UPD;
			ST_UPD:  state_d = emit ? ST_COPY : ST_IDLE;
			ST_COPY: state_d = ST_SCAN;
			ST_SCAN: if (int'(sc_q) == NTAP + 1) state_d = ST_DIVS;
			ST_DIVS: state_d = ST_DIV;
			ST_DIV:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Merge of the lane results into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x      <= ox_q;
			out_y      <= oy_q;
			out_b      <= res_v[0];
			out_g      <= (mode_q == MODE_MONO) ? 8'd0 : res_v[1];
			out_r      <= (mode_q == MODE_MONO) ? 8'd0 : res_v[2];
			out_alpha  <= (mode_q == MODE_BGRA) ? 8'hFF : 8'd0;
			frame_done <= fd_q;
		end
	end

endmodule
